### hw/rtl/drhs_pkg.sv
// drhs_pkg: field widths used by the date record heap sort.
// No dependencies.
package drhs_pkg;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 12;
   localparam int TAG_W   = 1;

endpackage

### hw/rtl/drhs_ram.sv
// drhs_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module drhs_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/date_record_heap_sort.sv
// date_record_heap_sort: collects date records and emits them heap-sorted by date.
// Depends on drhs_pkg (field widths) and drhs_ram (record store).
//
//   channel   ports                         handshake
//   -------   ---------------------------   ------------------------------------
//   request   req_rec_*, req_is_last        taken when start && !busy
//   response  rsp_out_*, rsp_overflow       one word per cycle while rsp_valid
//
// Busy stays low between loads of a set.
// The word marked is_last starts the sort (with fewer than two records the words go
// straight out); one shared read port of the store sets the pace of the heap build,
// the sift-downs and the streaming of the sorted words.
// Reset clears the count and flags; the store needs no clearing pass.
// The receiver cannot stall; sorted words go out on consecutive cycles.
module date_record_heap_sort #(
   parameter int MAX_RECORDS = 64,
   parameter int YEAR_BITS   = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [drhs_pkg::DAY_W-1:0]   req_rec_day,
   input  logic [drhs_pkg::MONTH_W-1:0] req_rec_month,
   input  logic [drhs_pkg::YEAR_W-1:0]  req_rec_year,
   input  logic [drhs_pkg::TAG_W-1:0]   req_rec_tag,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   output logic [drhs_pkg::DAY_W-1:0]   rsp_out_day,
   output logic [drhs_pkg::MONTH_W-1:0] rsp_out_month,
   output logic [drhs_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic [drhs_pkg::TAG_W-1:0]   rsp_out_tag,
   output logic                        rsp_out_last,
   output logic                        rsp_overflow
);

   localparam int YK = (YEAR_BITS < drhs_pkg::YEAR_W) ? YEAR_BITS : drhs_pkg::YEAR_W;
   localparam int DW = drhs_pkg::DAY_W;
   localparam int MW = drhs_pkg::MONTH_W;
   localparam int KW = YK + MW + DW;
   localparam int WW = KW + drhs_pkg::TAG_W;
   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_BLD_RD   = 11'b000_0000_0010,
      ST_BLD_GET  = 11'b000_0000_0100,
      ST_SIFT_L   = 11'b000_0000_1000,
      ST_SIFT_R   = 11'b000_0001_0000,
      ST_SIFT_CMP = 11'b000_0010_0000,
      ST_POP_RD1  = 11'b000_0100_0000,
      ST_POP_RD2  = 11'b000_1000_0000,
      ST_POP_SW   = 11'b001_0000_0000,
      ST_OUT      = 11'b010_0000_0000,
      ST_DRAIN    = 11'b100_0000_0000
   } state_type;

   function automatic logic [AW-1:0] pos_addr(input logic [CW-1:0] pos);
      logic [CW-1:0] t;
      t = pos - CW'(1);
      return t[AW-1:0];
   endfunction

   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] m_ff, m_in;
   logic [CW-1:0] node_ff, node_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          build_ff, build_in;
   logic [WW-1:0] carry_ff, carry_in;
   logic [WW-1:0] left_ff, left_in;
   logic [AW-1:0] oidx_ff, oidx_in;
   logic          emit_ff, emit_in;
   logic          emit_last_ff, emit_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [WW-1:0] rd_data;

   logic [CW:0]   lpos, rpos, lim_x;
   logic          has_left, has_right, pick_right, swap;
   logic [WW-1:0] child_val;
   logic [CW-1:0] child_pos;
   logic [CW-1:0] cnt_new;
   logic          accept, do_step, adv;

   drhs_ram #(
      .WIDTH(WW),
      .DEPTH(MAX_RECORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign lpos      = {node_ff, 1'b0};
   assign rpos      = {node_ff, 1'b1};
   assign lim_x     = {1'b0, lim_ff};
   assign has_left  = lpos <= lim_x;
   assign has_right = rpos <= lim_x;
   assign pick_right = (state_ff == ST_SIFT_CMP) && (left_ff[KW-1:0] < rd_data[KW-1:0]);

   always_comb begin
      if (state_ff == ST_SIFT_CMP) begin
         child_val = pick_right ? rd_data : left_ff;
      end else begin
         child_val = rd_data;
      end
      child_pos = pick_right ? rpos[CW-1:0] : lpos[CW-1:0];
   end

   assign swap = carry_ff[KW-1:0] < child_val[KW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      m_in         = m_ff;
      node_in      = node_ff;
      lim_in       = lim_ff;
      build_in     = build_ff;
      carry_in     = carry_ff;
      left_in      = left_ff;
      oidx_in      = oidx_ff;
      emit_in      = 1'b0;
      emit_last_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = pos_addr(node_ff);
      wr_data      = carry_ff;
      rd_addr      = '0;
      cnt_new      = count_ff;
      do_step      = 1'b0;
      adv          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_RECORDS)) begin
                  wr_en   = 1'b1;
                  wr_addr = count_ff[AW-1:0];
                  wr_data = {req_rec_tag, req_rec_year[YK-1:0], req_rec_month, req_rec_day};
                  cnt_new = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               count_in = cnt_new;
               if (req_is_last) begin
                  n_in = cnt_new;
                  if (cnt_new >= CW'(2)) begin
                     i_in     = cnt_new >> 1;
                     build_in = 1'b1;
                     state_in = ST_BLD_RD;
                  end else begin
                     oidx_in  = '0;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_BLD_RD: begin
            rd_addr  = pos_addr(i_ff);
            node_in  = i_ff;
            lim_in   = n_ff;
            state_in = ST_BLD_GET;
         end
         ST_BLD_GET: begin
            carry_in = rd_data;
            state_in = ST_SIFT_L;
         end
         ST_SIFT_L: begin
            if (has_left) begin
               rd_addr  = pos_addr(lpos[CW-1:0]);
               state_in = ST_SIFT_R;
            end else begin
               wr_en = 1'b1;
               adv   = 1'b1;
            end
         end
         ST_SIFT_R: begin
            left_in = rd_data;
            if (has_right) begin
               rd_addr  = pos_addr(rpos[CW-1:0]);
               state_in = ST_SIFT_CMP;
            end else begin
               do_step = 1'b1;
            end
         end
         ST_SIFT_CMP: begin
            do_step = 1'b1;
         end
         ST_POP_RD1: begin
            rd_addr  = '0;
            state_in = ST_POP_RD2;
         end
         ST_POP_RD2: begin
            rd_addr  = pos_addr(m_ff);
            left_in  = rd_data;
            state_in = ST_POP_SW;
         end
         ST_POP_SW: begin
            wr_en    = 1'b1;
            wr_addr  = pos_addr(m_ff);
            wr_data  = left_ff;
            carry_in = rd_data;
            node_in  = CW'(1);
            lim_in   = m_ff - CW'(1);
            state_in = ST_SIFT_L;
         end
         ST_OUT: begin
            rd_addr = oidx_ff;
            emit_in = 1'b1;
            if (CW'(oidx_ff) == n_ff - CW'(1)) begin
               emit_last_in = 1'b1;
               state_in     = ST_DRAIN;
            end else begin
               oidx_in = oidx_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_step) begin
         wr_en = 1'b1;
         if (swap) begin
            wr_data  = child_val;
            node_in  = child_pos;
            state_in = ST_SIFT_L;
         end else if (build_ff) begin
            adv = 1'b1;
         end else begin
            carry_in = child_val;
            node_in  = child_pos;
            state_in = ST_SIFT_L;
         end
      end

      if (adv) begin
         if (build_ff) begin
            if (i_ff > CW'(1)) begin
               i_in     = i_ff - CW'(1);
               state_in = ST_BLD_RD;
            end else begin
               build_in = 1'b0;
               m_in     = n_ff;
               state_in = ST_POP_RD1;
            end
         end else if (m_ff > CW'(2)) begin
            m_in     = m_ff - CW'(1);
            state_in = ST_POP_RD1;
         end else begin
            oidx_in  = '0;
            state_in = ST_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         build_ff     <= 1'b0;
         emit_ff      <= 1'b0;
         emit_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         build_ff     <= build_in;
         emit_ff      <= emit_in;
         emit_last_ff <= emit_last_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      i_ff     <= i_in;
      m_ff     <= m_in;
      node_ff  <= node_in;
      lim_ff   <= lim_in;
      carry_ff <= carry_in;
      left_ff  <= left_in;
      oidx_ff  <= oidx_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = emit_ff;
   assign rsp_out_last  = emit_last_ff;
   assign rsp_overflow  = ovf_ff;
   assign rsp_out_day   = rd_data[DW-1:0];
   assign rsp_out_month = rd_data[DW+MW-1:DW];
   assign rsp_out_year  = drhs_pkg::YEAR_W'(rd_data[KW-1:DW+MW]);
   assign rsp_out_tag   = rd_data[WW-1:KW];

endmodule

### hw/rtl/drhs_checker.sv
// drhs_checker: port-level checks on the date record heap sort, bound to the top.
// Depends on date_record_heap_sort port names only.
module drhs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_is_last,
   input logic rsp_valid,
   input logic rsp_out_last
);

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response word outside a busy period");

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_is_last) |=> busy)
      else $error("last word did not start the sort");

   a_words_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_last) |=> rsp_valid)
      else $error("gap in sorted word stream");

   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |=> (!rsp_valid && !busy))
      else $error("block still active after last word");

endmodule

bind date_record_heap_sort drhs_checker u_drhs_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_is_last (req_is_last),
   .rsp_valid   (rsp_valid),
   .rsp_out_last(rsp_out_last)
);
